>>> rtl/mtt_pkg.sv
`default_nettype none

package mtt_pkg;

	localparam int COORD_W = 32;
	localparam int MAG_W   = COORD_W + 1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int REG_W   = 20;
	localparam int DIST_W  = 34;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int SUB_W   = REM_W + 2;
	localparam int CNT_W   = 6;
	localparam int AXES    = 3;

	localparam logic [REG_W-1:0] STEP_RESET = REG_W'(1638);
	localparam logic [REG_W-1:0] TOL_RESET  = REG_W'(6554);

	localparam logic [1:0] ACT_GOAL   = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	localparam logic [2:0] STAT_ACCEPTED = 3'd0;
	localparam logic [2:0] STAT_MOVING   = 3'd1;
	localparam logic [2:0] STAT_REACHED  = 3'd2;
	localparam logic [2:0] STAT_CANCELED = 3'd3;
	localparam logic [2:0] STAT_IDLE     = 3'd4;

	localparam logic CFG_STEP = 1'b0;
	localparam logic CFG_TOL  = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0] mag_t;

endpackage

`default_nettype wire

>>> rtl/move_toward_target_3d_step.sv
`default_nettype none

// A goal, cancel or idle item gives its result in the cycle after acceptance.
// A tick with an armed goal squares the three axis distances on the shared
// multiplier and takes the square root; when the goal is not reached it also runs
// one division per axis to move. The square root and the divisions run on one shared
// subtractor. One item is in work at a time.
// Reset (arst_n low) clears position, goal and armed flag and restores the registers.
module move_toward_target_3d_step import mtt_pkg::*; (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire                       cfg_index,
	input  wire  [REG_W-1:0]          cfg_data,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire  [1:0]                action,
	input  wire  signed [COORD_W-1:0] target_x,
	input  wire  signed [COORD_W-1:0] target_y,
	input  wire  signed [COORD_W-1:0] target_z,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [2:0]                status,
	output logic [DIST_W-1:0]         distance,
	output logic signed [COORD_W-1:0] pos_out_x,
	output logic signed [COORD_W-1:0] pos_out_y,
	output logic signed [COORD_W-1:0] pos_out_z
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_SQRT  = 4'd3;
	localparam logic [3:0] ST_CHECK = 4'd4;
	localparam logic [3:0] ST_MULS  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_UPD   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]         state_q;
	logic [REG_W-1:0]   step_q;
	logic [REG_W-1:0]   tol_q;
	coord_t             pos_q [AXES];
	coord_t             goal_q [AXES];
	logic               armed_q;
	mag_t               mag_q [AXES];
	logic [AXES-1:0]    neg_q;
	logic [1:0]         axis_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SQ_W-1:0]    prod_q;
	logic [SQ_W-1:0]    acc_q;
	logic [SQ_W-1:0]    rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [REG_W-1:0]   num_q;
	logic [REG_W-1:0]   quo_q;
	logic [2:0]         stat_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [DIST_W-1:0]  distance_q;
	coord_t             pos_out_q [AXES];

	mag_t               mag_d [AXES];
	logic [AXES-1:0]    neg_d;
	logic [MAG_W-1:0]   mul_b;
	logic [SQ_W-1:0]    mul_p;
	logic [SUB_W-1:0]   sub_a;
	logic [SUB_W-1:0]   sub_b;
	logic [SUB_W:0]     sub_d;
	logic               sub_ge;
	logic [DIST_W-1:0]  root_dist;
	logic               out_free;
	logic               in_acc;
	logic               load_done;
	logic               out_set;
	logic [SQ_W-1:0]    acc_sum;
	logic [COORD_W+1:0] upd_sum;
	coord_t             upd_sat;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_acc    = in_valid && in_ready;
	assign load_done = (state_q == ST_DONE) && out_free;
	assign out_set   = (in_acc && !(action == ACT_TICK && armed_q)) || load_done;
	assign root_dist = DIST_W'(root_q);
	assign acc_sum   = acc_q + prod_q;

	always_comb begin
		logic [MAG_W-1:0] d;
		for (int i = 0; i < AXES; i++) begin
			d = {goal_q[i][COORD_W-1], goal_q[i]} - {pos_q[i][COORD_W-1], pos_q[i]};
			neg_d[i] = d[MAG_W-1];
			mag_d[i] = d[MAG_W-1] ? -d : d;
		end
	end

	assign mul_b = (state_q == ST_SQ) ? mag_q[axis_q] : MAG_W'(step_q);
	assign mul_p = mag_q[axis_q] * mul_b;

	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = {rem_q, rad_q[SQ_W-1 -: 2]};
			sub_b = SUB_W'({root_q, 2'b01});
		end else begin
			sub_a = SUB_W'({rem_q, num_q[REG_W-1]});
			sub_b = SUB_W'(root_dist);
		end
		sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_d[SUB_W];
	end

	always_comb begin
		logic [COORD_W+1:0] qx;
		qx      = (COORD_W + 2)'(quo_q);
		upd_sum = {{2{pos_q[axis_q][COORD_W-1]}}, pos_q[axis_q]} + (neg_q[axis_q] ? -qx : qx);
		if (upd_sum[COORD_W+1:COORD_W-1] == 3'b000 || upd_sum[COORD_W+1:COORD_W-1] == 3'b111) begin
			upd_sat = upd_sum[COORD_W-1:0];
		end else if (upd_sum[COORD_W+1]) begin
			upd_sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			upd_sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_RESET;
			tol_q       <= TOL_RESET;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
			axis_q      <= '0;
			cnt_q       <= '0;
			for (int i = 0; i < AXES; i++) begin
				pos_q[i]  <= '0;
				goal_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STEP: step_q <= cfg_data;
					CFG_TOL:  tol_q  <= cfg_data;
					default:  ;
				endcase
			end
			out_valid_q <= out_set || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action == ACT_GOAL) begin
							goal_q[0]   <= target_x;
							goal_q[1]   <= target_y;
							goal_q[2]   <= target_z;
							armed_q     <= 1'b1;
						end else if (action == ACT_CANCEL) begin
							armed_q     <= 1'b0;
						end else if (action == ACT_TICK && armed_q) begin
							axis_q  <= '0;
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (axis_q == 2'(AXES - 1)) begin
						cnt_q   <= CNT_W'(ROOT_W - 1);
						state_q <= ST_SQRT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_SQ;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_CHECK: begin
					axis_q <= '0;
					if (root_dist < DIST_W'(tol_q) || root_dist == '0) begin
						armed_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MULS;
					end
				end
				ST_MULS: begin
					cnt_q   <= CNT_W'(REG_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_UPD: begin
					pos_q[axis_q] <= upd_sat;
					if (axis_q == 2'(AXES - 1)) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MULS;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < AXES; i++) begin
					mag_q[i] <= mag_d[i];
				end
				neg_q  <= neg_d;
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQ: begin
				prod_q <= mul_p;
			end
			ST_ACC: begin
				acc_q <= acc_sum;
				rad_q <= acc_sum;
			end
			ST_SQRT: begin
				rad_q <= {rad_q[SQ_W-3:0], 2'b00};
				if (sub_ge) begin
					rem_q  <= sub_d[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= sub_a[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			ST_CHECK: begin
				if (root_dist < DIST_W'(tol_q) || root_dist == '0) begin
					stat_q <= STAT_REACHED;
				end else begin
					stat_q <= STAT_MOVING;
				end
			end
			ST_MULS: begin
				rem_q <= REM_W'(mul_p[MAG_W+REG_W-1:REG_W]);
				num_q <= mul_p[REG_W-1:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				num_q <= {num_q[REG_W-2:0], 1'b0};
				if (sub_ge) begin
					rem_q <= sub_d[REM_W-1:0];
					quo_q <= {quo_q[REG_W-2:0], 1'b1};
				end else begin
					rem_q <= sub_a[REM_W-1:0];
					quo_q <= {quo_q[REG_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase

		if (in_acc) begin
			distance_q <= '0;
			for (int i = 0; i < AXES; i++) begin
				pos_out_q[i] <= pos_q[i];
			end
			if (action == ACT_GOAL) begin
				status_q <= STAT_ACCEPTED;
			end else if (action == ACT_CANCEL) begin
				status_q <= STAT_CANCELED;
			end else begin
				status_q <= STAT_IDLE;
			end
		end else if (load_done) begin
			status_q   <= stat_q;
			distance_q <= root_dist;
			for (int i = 0; i < AXES; i++) begin
				pos_out_q[i] <= pos_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign distance  = distance_q;
	assign pos_out_x = pos_out_q[0];
	assign pos_out_y = pos_out_q[1];
	assign pos_out_z = pos_out_q[2];

	a_div_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> REM_W'(root_dist) > rem_q)
		else $error("division remainder not below distance");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> quo_q <= step_q)
		else $error("axis step exceeds step length");

	a_moving_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_MOVING |-> distance != '0 && distance >= DIST_W'(tol_q))
		else $error("moving result with distance inside tolerance");

	a_plain_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_ACCEPTED || status == STAT_CANCELED ||
		status == STAT_IDLE) |-> distance == '0)
		else $error("nonzero distance on a result without distance");

	a_tick_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK && (root_dist < DIST_W'(tol_q) || root_dist == '0) |=> !armed_q)
		else $error("goal still armed after reaching it");

endmodule

`default_nettype wire
